>>> hdl/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg
// shared types, constants and helpers of the rgb 3x3 convolution filter
// ----------------------------------------------------------------------------
package rcf_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 4096;
	localparam int ColW      = $clog2(MaxWidth);
	localparam int CntW      = 22;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 13;
	localparam int QDepth    = 8;
	localparam int QPtrW     = $clog2(QDepth);

	localparam logic [CfgIdxW-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_LEFT   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TOP    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_RIGHT  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_BOTTOM = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_MODE   = 3'd6;

	typedef enum logic [1:0] {
		MODE_EDGE    = 2'd0,
		MODE_SHARPEN = 2'd1,
		MODE_BOX     = 2'd2,
		MODE_GAUSS   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [10:0] width;
		logic [12:0] height;
		logic [9:0]  left;
		logic [11:0] top;
		logic [10:0] right;
		logic [12:0] bottom;
		mode_t       mode;
	} cfg_t;

	// one classified word handed from front to back
	typedef struct packed {
		logic        filt;
		logic        last;
		logic [23:0] p0, p1, p2, p3, p4, p5, p6, p7, p8;
	} job_t;

	// clamp a signed sum to 0..255
	function automatic logic [7:0] clamp8(input logic signed [13:0] v);
		if (v < 0) return 8'd0;
		else if (v > 14'sd255) return 8'd255;
		else return v[7:0];
	endfunction

endpackage

>>> hdl/rcf_front.sv
// ----------------------------------------------------------------------------
// rcf_front
// row stores, window and position tracking; classifies each output word
// ----------------------------------------------------------------------------
module rcf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  rcf_pkg::cfg_t  cfg,
	input  logic           push,
	input  logic [7:0]     red_in,
	input  logic [7:0]     green_in,
	input  logic [7:0]     blue_in,
	input  logic           drain,
	output logic           ready,
	output logic           job_valid,
	output rcf_pkg::job_t  job
);
	import rcf_pkg::*;

	logic [23:0] store1 [MaxWidth];
	logic [23:0] store2 [MaxWidth];
	logic [23:0] rd1_q, rd2_q, byp1_q, byp2_q;
	logic byp_q;
	logic [ColW-1:0] ra_q;
	logic [23:0] win_q [6];
	logic [12:0] col_q;
	logic [12:0] row_q;
	logic [CntW-1:0] cnt_q;

	logic [10:0] w;
	logic [12:0] h;
	logic [CntW:0] total, cnt_x;
	logic [12:0] c, c_inc, col_nx, ra_full;
	logic [ColW-1:0] ci, ra;
	logic [23:0] pix, top, mid;
	logic idle_drain, act, emit, last, wrap, border, sel;
	logic [12:0] orow, ocol;

	always_comb begin
		w = (cfg.width == '0) ? 11'd1 : (cfg.width > 11'(MaxWidth) ? 11'(MaxWidth) : cfg.width);
		h = (cfg.height == '0) ? 13'd1
			: (cfg.height > 13'(MaxHeight) ? 13'(MaxHeight) : cfg.height);
		total = (CntW+1)'(w) * (CntW+1)'(h);
		cnt_x = {1'b0, cnt_q};
		c = (col_q >= 13'(w)) ? 13'(w) - 13'd1 : col_q;
		ci = c[ColW-1:0];
		c_inc = c + 13'd1;
		pix = drain ? 24'd0 : {red_in, green_in, blue_in};
		// same-column write on the previous word bypasses the store read
		mid = byp_q ? byp1_q : rd1_q;
		top = byp_q ? byp2_q : rd2_q;
		idle_drain = drain && col_q == '0 && row_q == '0 && cnt_q == '0;
		act = push && !idle_drain;
		emit = ((row_q >= 13'd2) || (row_q == 13'd1 && c >= 13'd1)) && (cnt_x < total);
		last = cnt_x == total - (CntW+1)'(1);
		wrap = (emit && last) || (!emit && cnt_x >= total);
		// column of the next word, read ahead from the stores
		col_nx = col_q;
		if (act) col_nx = (wrap || c_inc >= 13'(w)) ? '0 : c_inc;
		ra_full = (col_nx >= 13'(w)) ? 13'(w) - 13'd1 : col_nx;
		ra = ra_full[ColW-1:0];
		orow = (c >= 13'd1) ? row_q - 13'd1 : row_q - 13'd2;
		ocol = (c >= 13'd1) ? c - 13'd1 : 13'(w) - 13'd1;
		border = orow == '0 || orow + 13'd1 >= h || ocol == '0 || ocol + 13'd1 >= 13'(w);
		sel = ocol >= 13'(cfg.left) && ocol < 13'(cfg.right)
			&& orow >= 13'(cfg.top) && orow < cfg.bottom;
	end

	// read data is valid once the read-ahead column matches the current one
	assign ready = ra_q == ci;

	// row stores with registered read at the read-ahead column
	always_ff @(posedge clk) begin
		if (act) begin
			store2[ci] <= mid;
			store1[ci] <= pix;
		end
		rd1_q <= store1[ra];
		rd2_q <= store2[ra];
	end

	always_ff @(posedge clk) begin
		byp1_q <= pix;
		byp2_q <= mid;
		if (act) begin
			win_q[0] <= win_q[3]; win_q[1] <= win_q[4]; win_q[2] <= win_q[5];
			win_q[3] <= top;      win_q[4] <= mid;      win_q[5] <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
			ra_q <= '0;
			byp_q <= 1'b0;
			job_valid <= 1'b0;
		end else begin
			job_valid <= act && emit;
			ra_q <= ra;
			byp_q <= act && (ci == ra);
			if (act) begin
				col_q <= col_nx;
				if (wrap) begin
					row_q <= '0; cnt_q <= '0;
				end else begin
					if (c_inc >= 13'(w)) row_q <= row_q + 13'd1;
					if (emit) cnt_q <= cnt_q + CntW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act) begin
			job.filt <= !border && sel;
			job.last <= last;
			job.p0 <= win_q[0]; job.p1 <= win_q[3]; job.p2 <= top;
			job.p3 <= win_q[1]; job.p4 <= win_q[4]; job.p5 <= mid;
			job.p6 <= win_q[2]; job.p7 <= win_q[5]; job.p8 <= pix;
		end
	end

endmodule

>>> hdl/rcf_back.sv
// ----------------------------------------------------------------------------
// rcf_back
// kernel arithmetic for one word, two stages
// ----------------------------------------------------------------------------
module rcf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  rcf_pkg::mode_t  mode,
	input  logic            in_valid,
	input  logic            stall,
	input  rcf_pkg::job_t   job,
	output logic            out_valid,
	output logic [23:0]     pixel,
	output logic            last
);
	import rcf_pkg::*;

	logic signed [13:0] sum_s1 [3];
	logic [23:0] ctr_s1;
	logic filt_s1, last_s1, v_s1;
	mode_t mode_s1;
	logic [23:0] res;

	function automatic logic signed [13:0] ksum(input job_t j, input int sh, input mode_t m);
		logic signed [13:0] p [9];
		logic signed [13:0] nb, cr;
		p[0] = 14'(j.p0[sh+:8]); p[1] = 14'(j.p1[sh+:8]); p[2] = 14'(j.p2[sh+:8]);
		p[3] = 14'(j.p3[sh+:8]); p[4] = 14'(j.p4[sh+:8]); p[5] = 14'(j.p5[sh+:8]);
		p[6] = 14'(j.p6[sh+:8]); p[7] = 14'(j.p7[sh+:8]); p[8] = 14'(j.p8[sh+:8]);
		nb = p[0] + p[2] + p[6] + p[8];
		cr = p[1] + p[3] + p[5] + p[7];
		case (m)
			MODE_EDGE:    return (p[4] <<< 3) - nb - cr;
			MODE_SHARPEN: return 14'sd5 * p[4] - cr;
			MODE_BOX:     return nb + cr + p[4] + 14'sd4;
			default:      return nb + (cr <<< 1) + (p[4] <<< 2) + 14'sd8;
		endcase
	endfunction

	// rounded sum / 9 for 0..2299 by reciprocal multiply
	function automatic logic [7:0] div9(input logic signed [13:0] s);
		logic [25:0] prod;
		prod = 26'(s[11:0]) * 26'd7282;
		return prod[23:16];
	endfunction

	function automatic logic [7:0] fin(input logic signed [13:0] s, input mode_t m);
		case (m)
			MODE_BOX:   return div9(s);
			MODE_GAUSS: return s[11:4];
			default:    return clamp8(s);
		endcase
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (!stall) begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			sum_s1[0] <= ksum(job, 16, mode);
			sum_s1[1] <= ksum(job, 8, mode);
			sum_s1[2] <= ksum(job, 0, mode);
			ctr_s1 <= job.p4;
			filt_s1 <= job.filt;
			last_s1 <= job.last;
			mode_s1 <= mode;
			pixel <= res;
			last <= last_s1;
		end
	end

	assign res = filt_s1 ? {fin(sum_s1[0], mode_s1), fin(sum_s1[1], mode_s1),
		fin(sum_s1[2], mode_s1)} : ctr_s1;

endmodule

>>> hdl/rgb_conv3x3_filter.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_filter
// 3x3 rgb convolution over a raster stream with a selection rectangle
// ----------------------------------------------------------------------------
// release: a word is released by the input word one row plus one pixel after
//   the pixel itself, then passes the front job register and both back stages
// throughput: one input word per cycle; full rises when queue plus back pipe
//   hold eight words, or for one cycle after a register write moves the column
// reset: arst_n clears position, counters, queue and registers to defaults;
//   row stores hold no reset value and need no clearing pass
module rgb_conv3x3_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic        drain,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        frame_last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [12:0] cfg_data
);
	import rcf_pkg::*;

	cfg_t cfg_q;
	logic job_valid, jv1_q, bv, bl, front_ready;
	job_t job;
	logic [23:0] bpix;
	// output queue; its room also covers every word still in the back pipe
	logic [24:0] fifo_q [QDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QPtrW:0] cnt_q;
	logic [QPtrW:0] used;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{width: 11'd1024, height: 13'd1, left: '0, top: '0,
				right: 11'd1024, bottom: 13'd1, mode: MODE_EDGE};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WIDTH:  cfg_q.width  <= cfg_data[10:0];
				REG_HEIGHT: cfg_q.height <= cfg_data;
				REG_LEFT:   cfg_q.left   <= cfg_data[9:0];
				REG_TOP:    cfg_q.top    <= cfg_data[11:0];
				REG_RIGHT:  cfg_q.right  <= cfg_data[10:0];
				REG_BOTTOM: cfg_q.bottom <= cfg_data;
				REG_MODE:   cfg_q.mode   <= mode_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// front: takes each pushed word while full is low
	rcf_front u_front (
		.clk, .arst_n, .cfg(cfg_q), .push(push && !full),
		.red_in, .green_in, .blue_in, .drain, .ready(front_ready), .job_valid, .job
	);

	// back: free-running pipe, the queue reserves room for everything in it
	rcf_back u_back (
		.clk, .arst_n, .mode(cfg_q.mode), .in_valid(job_valid), .stall(1'b0),
		.job, .out_valid(bv), .pixel(bpix), .last(bl)
	);

	// mirror of the back pipe's first stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) jv1_q <= 1'b0;
		else jv1_q <= job_valid;
	end

	// queued words plus words in the three pipe stages
	assign used = cnt_q + (QPtrW+1)'(job_valid) + (QPtrW+1)'(jv1_q) + (QPtrW+1)'(bv);
	assign full = !front_ready || used >= (QPtrW+1)'(QDepth);
	assign empty = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (bv) wp_q <= wp_q + QPtrW'(1);
			if (pop && !empty) rp_q <= rp_q + QPtrW'(1);
			cnt_q <= cnt_q + (QPtrW+1)'(bv) - (QPtrW+1)'(pop && !empty);
		end
	end

	always_ff @(posedge clk) begin
		if (bv) fifo_q[wp_q] <= {bl, bpix};
	end

	assign {frame_last, red_out, green_out, blue_out} = fifo_q[rp_q];

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		bv |-> (cnt_q < (QPtrW+1)'(QDepth))) else $error("queue overflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPtrW+1)'(QDepth)) else $error("queue count range");
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		used <= (QPtrW+1)'(QDepth)) else $error("in-flight count");
`endif

endmodule

>>> tb/tb_rgb_conv3x3_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_conv3x3_filter
// self-checking bench for the rgb 3x3 convolution filter
// ----------------------------------------------------------------------------
// whole frames are streamed in raster order, then width+1 tail words (all
// drains but one colour word) so that every pixel comes out. an in-bench
// predictor keeps its own row stores, window and position, and queues the
// expected output word of each accepted word that releases one. a checker
// pops output words at random and compares them field by field. registers
// change only between frames, once idle; no filtered word sees unwritten rows.
// ----------------------------------------------------------------------------
module tb_rgb_conv3x3_filter;
	import rcf_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  red_in, green_in, blue_in;
	logic        drain;
	logic        empty;
	logic        pop;
	logic [7:0]  red_out, green_out, blue_out;
	logic        frame_last;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [12:0] cfg_data;

	rgb_conv3x3_filter uut (.*);

	typedef struct packed {
		logic [7:0] r, g, b;
		logic       last;
	} pix_word_t;

	// predictor state
	logic [23:0] line_above [MaxWidth];
	logic [23:0] line_above2[MaxWidth];
	logic [23:0] win_regs[6];
	int unsigned col_pos, row_pos, out_pixels;
	cfg_t        shadow_cfg;

	pix_word_t   pending_pixels[$];
	int unsigned mismatches;
	longint      cycle_count;
	bit          feed_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop for a hung block
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("error @%0t: %s", $realtime, what);
	endtask

	function automatic logic [7:0] sat8(input int v);
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	// weighted sum of one channel of the 3x3 neighborhood
	function automatic logic [7:0] conv_channel(input logic [23:0] nb[9], input int sh);
		int p[9];
		int s;
		for (int i = 0; i < 9; i++) p[i] = (nb[i] >> sh) & 8'hff;
		case (shadow_cfg.mode)
			MODE_EDGE: begin
				s = 8 * p[4] - (p[0] + p[1] + p[2] + p[3] + p[5] + p[6] + p[7] + p[8]);
				return sat8(s);
			end
			MODE_SHARPEN: begin
				s = 5 * p[4] - (p[1] + p[3] + p[5] + p[7]);
				return sat8(s);
			end
			MODE_BOX: begin
				s = 0;
				for (int i = 0; i < 9; i++) s += p[i];
				return sat8((s + 4) / 9);
			end
			default: begin
				s = p[0] + 2 * p[1] + p[2] + 2 * p[3] + 4 * p[4] + 2 * p[5]
					+ p[6] + 2 * p[7] + p[8];
				return sat8((s + 8) >> 4);
			end
		endcase
	endfunction

	function automatic void reset_prediction();
		for (int i = 0; i < 6; i++) win_regs[i] = '0;
		col_pos = 0;
		row_pos = 0;
		out_pixels = 0;
		shadow_cfg = '{width: 11'd1024, height: 13'd1, left: '0, top: '0,
			right: 11'd1024, bottom: 13'd1, mode: MODE_EDGE};
	endfunction

	// advance the filter model by one accepted input word
	function automatic void predict_filter(input logic [23:0] px_in, input logic is_drain);
		int unsigned w, h, total, c, r, orow, ocol;
		logic [23:0] px, top_px, mid_px;
		logic [23:0] nb[9];
		pix_word_t   o;
		bit          emit, border, sel, was_last;
		w = shadow_cfg.width;
		h = shadow_cfg.height;
		if (w == 0) w = 1;
		if (w > MaxWidth) w = MaxWidth;
		if (h == 0) h = 1;
		if (h > MaxHeight) h = MaxHeight;
		total = w * h;
		was_last = 0;
		// idle drain: nothing happens at the start of a frame
		if (is_drain && col_pos == 0 && row_pos == 0 && out_pixels == 0) return;
		px = is_drain ? 24'h0 : px_in;
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = row_pos;
		top_px = line_above2[c];
		mid_px = line_above[c];
		line_above2[c] = mid_px;
		line_above[c] = px;
		emit = (r >= 2) || (r == 1 && c >= 1);
		if (out_pixels >= total) emit = 0;
		if (emit) begin
			orow = (c >= 1) ? r - 1 : r - 2;
			ocol = (c >= 1) ? c - 1 : w - 1;
			border = orow == 0 || orow + 1 >= h || ocol == 0 || ocol + 1 >= w;
			sel = ocol >= shadow_cfg.left && ocol < shadow_cfg.right &&
				orow >= shadow_cfg.top && orow < shadow_cfg.bottom;
			if (!border && sel) begin
				nb = '{win_regs[0], win_regs[3], top_px, win_regs[1], win_regs[4],
					mid_px, win_regs[2], win_regs[5], px};
				o.r = conv_channel(nb, 16);
				o.g = conv_channel(nb, 8);
				o.b = conv_channel(nb, 0);
			end else begin
				o.r = win_regs[4][23:16];
				o.g = win_regs[4][15:8];
				o.b = win_regs[4][7:0];
			end
			o.last = (out_pixels == total - 1);
			was_last = o.last;
			out_pixels = (out_pixels + 1) & 32'h3fffff;
			pending_pixels.push_back(o);
		end
		win_regs[0] = win_regs[3];
		win_regs[1] = win_regs[4];
		win_regs[2] = win_regs[5];
		win_regs[3] = top_px;
		win_regs[4] = mid_px;
		win_regs[5] = px;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1) & 32'h1fff;
		end else begin
			col_pos = c + 1;
		end
		if (out_pixels >= total || was_last) begin
			col_pos = 0;
			row_pos = 0;
			out_pixels = 0;
		end
	endfunction

	// send one word, waiting a random gap first; push stays high afterwards
	task automatic send_word(input logic [23:0] px, input logic is_drain);
		int gap;
		gap = int'($urandom_range(0, 11) * ($urandom_range(0, 3) != 0));
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push     <= 1'b1;
		red_in   <= px[23:16];
		green_in <= px[15:8];
		blue_in  <= px[7:0];
		drain    <= is_drain;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_filter(px, is_drain);
		@(negedge clk);
	endtask

	// register write, only while the block is idle; cfg_we stays high afterwards
	task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_WIDTH:  shadow_cfg.width  = val[10:0];
			REG_HEIGHT: shadow_cfg.height = val[12:0];
			REG_LEFT:   shadow_cfg.left   = val[9:0];
			REG_TOP:    shadow_cfg.top    = val[11:0];
			REG_RIGHT:  shadow_cfg.right  = val[10:0];
			REG_BOTTOM: shadow_cfg.bottom = val[12:0];
			REG_MODE:   shadow_cfg.mode   = mode_t'(val[1:0]);
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_frame(input int w, input int h, input int l, input int t,
			input int rt, input int b, input mode_t m);
		wait_idle();
		write_reg(REG_WIDTH, 13'(w));
		write_reg(REG_HEIGHT, 13'(h));
		write_reg(REG_LEFT, 13'(l));
		write_reg(REG_TOP, 13'(t));
		write_reg(REG_RIGHT, 13'(rt));
		write_reg(REG_BOTTOM, 13'(b));
		write_reg(REG_MODE, 13'(m));
		cfg_we <= 1'b0;
	endtask

	// one full frame; pat 0 random, 1 all white, 2 all black, 3 checker
	task automatic send_frame(input int pat, input int early_drains);
		int unsigned w, h;
		logic [23:0] px;
		w = (shadow_cfg.width == 0) ? 1 : shadow_cfg.width;
		if (w > MaxWidth) w = MaxWidth;
		h = (shadow_cfg.height == 0) ? 1 : shadow_cfg.height;
		if (h > MaxHeight) h = MaxHeight;
		for (int i = 0; i < w * h; i++) begin
			case (pat)
				1: px = 24'hffffff;
				2: px = 24'h000000;
				3: px = ((i + (i / w)) % 2) ? 24'hffffff : 24'h000000;
				default: px = $urandom;
			endcase
			// an early drain stands for a black pixel
			if (i > 0 && early_drains > 0 && $urandom_range(0, 15) == 0) begin
				send_word($urandom, 1'b1);
				early_drains--;
			end else begin
				send_word(px, 1'b0);
			end
		end
		// flush the tail, with one extra colour word acting as a drain
		for (int i = 0; i <= w; i++) send_word($urandom, i != 1);
	endtask

	// -------- test tasks --------

	task automatic test_directed_extremes();
		// idle drain at frame start is ignored
		set_frame(4, 4, 0, 0, 4, 4, MODE_EDGE);
		send_word(24'hffffff, 1'b1);
		send_frame(3, 0);
		set_frame(4, 3, 0, 0, 4, 3, MODE_SHARPEN);
		send_frame(1, 0);
		set_frame(3, 3, 0, 0, 3, 3, MODE_BOX);
		send_frame(1, 0);
	endtask

	task automatic test_each_kernel();
		for (int m = 0; m < 4; m++) begin
			set_frame(5, 4, 1, 1, 4, 3, mode_t'(m));
			send_frame(3, 0);
			send_frame(0, 0);
		end
	endtask

	task automatic test_odd_settings();
		// width and height 0 act as 1; the next frame's empty selection passes all
		set_frame(0, 0, 0, 0, 1024, 4096, MODE_GAUSS);
		send_frame(0, 0);
		set_frame(6, 4, 5, 0, 2, 4, MODE_EDGE);
		send_frame(0, 0);
		set_frame(1, 5, 0, 0, 1, 5, MODE_BOX);
		send_frame(0, 0);
		// width above the maximum acts as the maximum, one row
		set_frame(2047, 1, 1023, 4095, 2047, 8191, MODE_SHARPEN);
		send_frame(0, 0);
		// early drains inside a frame
		set_frame(7, 5, 0, 0, 7, 5, MODE_GAUSS);
		send_frame(0, 4);
	endtask

	task automatic test_random_frames();
		int w, h;
		int sent;
		sent = 0;
		while (sent < 300) begin
			w = $urandom_range(1, 14);
			h = $urandom_range(1, 10);
			set_frame(w, h, $urandom_range(0, w), $urandom_range(0, h),
				$urandom_range(0, w + 1), $urandom_range(0, h + 1),
				mode_t'($urandom_range(0, 3)));
			send_frame(0, ($urandom_range(0, 7) == 0) ? 2 : 0);
			sent += w * h + w + 1;
		end
	endtask

	// -------- output checker --------

	// before each word pop may stay low for a random gap; none once feeding is done
	initial begin : pop_driver
		int gap;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = feed_done ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		pix_word_t want;
		if (arst_n && pop && !empty) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("output word with nothing expected");
			end else begin
				want = pending_pixels.pop_front();
				if (red_out !== want.r)
					report_mismatch($sformatf("red %0h want %0h", red_out, want.r));
				if (green_out !== want.g)
					report_mismatch($sformatf("green %0h want %0h", green_out, want.g));
				if (blue_out !== want.b)
					report_mismatch($sformatf("blue %0h want %0h", blue_out, want.b));
				if (frame_last !== want.last)
					report_mismatch($sformatf("frame_last %0b want %0b",
						frame_last, want.last));
			end
		end
	end

	initial begin
		int guard;
		arst_n = 1'b0;
		push = 1'b0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		drain = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_WIDTH;
		cfg_data = '0;
		mismatches = 0;
		cycle_count = 0;
		feed_done = 0;
		reset_prediction();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_extremes();
		test_each_kernel();
		test_odd_settings();
		test_random_frames();

		push <= 1'b0;
		feed_done = 1;
		guard = 0;
		while (pending_pixels.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (20) @(negedge clk);
		if (pending_pixels.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", pending_pixels.size()));
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
